/* rtl/core/assert_macros.svh */
// assertion macros, used by the top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clk edge, off while reset is asserted
`define ESL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every rising clk edge, reset included
`define ESL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/esled_pkg.sv */
// types and constants for the encoder selector with led patterns
package esled_pkg;

    localparam int SelectorLeds   = 6;
    localparam int StripLength    = 24;
    localparam int ColorW         = 24;
    localparam int PosW           = 3;
    localparam int IndexW         = 5;
    localparam int ClickW         = 6;
    localparam int ElapsedW       = 7;
    localparam int CountW         = 6;

    localparam logic [PosW-1:0]     MaxPos      = PosW'(SelectorLeds - 1);
    localparam logic [IndexW-1:0]   OffsetLimit = IndexW'(StripLength - SelectorLeds);
    localparam logic [ElapsedW-1:0] ElapsedMax  = '1;
    localparam logic [ElapsedW-1:0] BlinkMs     = ElapsedW'(50);
    localparam logic [ElapsedW-1:0] FanfareMs   = ElapsedW'(100);
    localparam logic [CountW-1:0]   BlinkEnd    = CountW'(8);
    localparam logic [CountW-1:0]   FanfareEnd  = CountW'(40);
    localparam logic [ClickW-1:0]   ClickNone   = '1;

    // stream word widths
    localparam int InDataW  = 40;
    localparam int OutDataW = 160;
    localparam int CfgIdxW  = 2;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_NORMAL  = 2'd1,
        MODE_BLINK   = 2'd2,
        MODE_FANFARE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        START_NONE    = 3'd0,
        START_OFF     = 3'd1,
        START_NORMAL  = 3'd2,
        START_BLINK   = 3'd3,
        START_FANFARE = 3'd4
    } start_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PIXEL_OFFSET   = 2'd0,
        CFG_PLAYER_COLOR   = 2'd1,
        CFG_ENCODER_ENABLE = 2'd2,
        CFG_PLAYER_ENABLE  = 2'd3
    } cfg_reg_t;

    typedef logic [ColorW-1:0] color_t;

endpackage

/* rtl/core/encoder_selector_with_led_patterns_top.sv */
// encoder selector with six-led pattern player, stream in and out
// an accepted word's result is registered in the output or, on a stall, the skid register
// throughput: one word per cycle while no word waits in the skid register; all of a
// step is one level of logic between the state registers and the output register,
// and a skid register keeps input ready high while an output word is stalled, until it fills
// reset: rst_n low clears selector, modes, counters and leds (elapsed saturated,
// click mark none) and all configuration registers to zero
`include "assert_macros.svh"

module encoder_selector_with_led_patterns_top
    import esled_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input words
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // enc_a, enc_b, button_level, ms_tick, load_position, new_position[3],
    // start_mode[3], mode_color[24], zero pad
    input  logic [InDataW-1:0]  s_axis_tdata,
    // result words
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // led0_color..led5_color[24 each], frame_changed, selected_index[5],
    // clicked_index[6], light_mode[2], zero pad
    output logic [OutDataW-1:0] m_axis_tdata,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [ColorW-1:0]   cfg_data
);

    // configuration registers
    logic [IndexW-1:0] pixel_offset_reg;
    color_t            player_color_reg;
    logic              encoder_enable_reg;
    logic              player_enable_reg;

    // step state
    logic [PosW-1:0]     sel_pos_reg,    sel_pos_next;
    logic                last_a_reg,     last_a_next;
    logic                btn_held_reg,   btn_held_next;
    logic [ClickW-1:0]   click_reg,      click_next;
    mode_t               mode_reg,       mode_next;
    color_t              pat_color_reg,  pat_color_next;
    logic                blink_lit_reg,  blink_lit_next;
    logic [CountW-1:0]   count_reg,      count_next;
    logic [ElapsedW-1:0] elapsed_reg,    elapsed_next;
    color_t              frame_reg [SelectorLeds];
    color_t              frame_next [SelectorLeds];

    // output register and skid register
    logic                out_valid_reg,  out_valid_next;
    logic [OutDataW-1:0] out_data_reg,   out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [OutDataW-1:0] skid_data_reg,  skid_data_next;

    // unpacked input word
    logic              enc_a;
    logic              enc_b;
    logic              button_level;
    logic              ms_tick;
    logic              load_position;
    logic [PosW-1:0]   new_position;
    logic [2:0]        start_mode;
    color_t            mode_color;

    logic              accept;
    logic              changed;
    logic [IndexW-1:0] off_clamped;
    logic [IndexW-1:0] abs_index;
    logic [OutDataW-1:0] result_word;

    assign enc_a         = s_axis_tdata[0];
    assign enc_b         = s_axis_tdata[1];
    assign button_level  = s_axis_tdata[2];
    assign ms_tick       = s_axis_tdata[3];
    assign load_position = s_axis_tdata[4];
    assign new_position  = s_axis_tdata[7:5];
    assign start_mode    = s_axis_tdata[10:8];
    assign mode_color    = s_axis_tdata[34:11];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration writes, taken whenever offered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_offset_reg   <= '0;
            player_color_reg   <= '0;
            encoder_enable_reg <= 1'b0;
            player_enable_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PIXEL_OFFSET:   pixel_offset_reg   <= cfg_data[IndexW-1:0];
                CFG_PLAYER_COLOR:   player_color_reg   <= cfg_data;
                CFG_ENCODER_ENABLE: encoder_enable_reg <= cfg_data[0];
                CFG_PLAYER_ENABLE:  player_enable_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // one full step of the selector and player
    always_comb
    begin
        logic [1:0] bar_k;
        logic       bar_on;

        sel_pos_next   = sel_pos_reg;
        last_a_next    = last_a_reg;
        btn_held_next  = btn_held_reg;
        click_next     = click_reg;
        mode_next      = mode_reg;
        pat_color_next = pat_color_reg;
        blink_lit_next = blink_lit_reg;
        count_next     = count_reg;
        elapsed_next   = elapsed_reg;
        frame_next     = frame_reg;
        changed        = 1'b0;
        bar_k          = count_reg[1:0];
        bar_on         = 1'b0;

        // position load, saturated to the last led
        if (load_position)
        begin
            sel_pos_next = (new_position > MaxPos) ? MaxPos : new_position;
        end

        // mode start, unknown codes ignored
        if (start_mode inside {START_OFF, START_NORMAL, START_BLINK, START_FANFARE})
        begin
            mode_next      = mode_t'(2'(start_mode - 3'd1));
            pat_color_next = mode_color;
        end

        // millisecond count, saturating
        if (ms_tick && elapsed_reg != ElapsedMax)
        begin
            elapsed_next = elapsed_reg + ElapsedW'(1);
        end

        // encoder: a change on a moves the selector, direction from b
        if (encoder_enable_reg)
        begin
            if (enc_a != last_a_reg)
            begin
                if (enc_b != enc_a)
                begin
                    if (sel_pos_next < MaxPos)
                    begin
                        sel_pos_next = sel_pos_next + PosW'(1);
                        frame_next   = '{default: '0};
                        changed      = 1'b1;
                    end
                end
                else if (sel_pos_next != '0)
                begin
                    sel_pos_next = sel_pos_next - PosW'(1);
                    frame_next   = '{default: '0};
                    changed      = 1'b1;
                end
            end
            last_a_next = enc_a;
        end

        if (player_enable_reg)
        begin
            case (mode_next)
                MODE_OFF:
                begin
                    mode_next  = MODE_NORMAL;
                    click_next = ClickNone;
                end
                MODE_NORMAL:
                begin
                    for (int i = 0; i < SelectorLeds; i++)
                    begin
                        if (sel_pos_next == PosW'(i))
                        begin
                            frame_next[i] = player_color_reg;
                        end
                    end
                    changed = 1'b1;
                end
                MODE_BLINK:
                begin
                    if (count_reg == BlinkEnd)
                    begin
                        mode_next      = MODE_NORMAL;
                        elapsed_next   = ElapsedMax;
                        blink_lit_next = 1'b0;
                        count_next     = '0;
                    end
                    else if (elapsed_next >= BlinkMs)
                    begin
                        if (blink_lit_reg)
                        begin
                            frame_next     = '{default: '0};
                            blink_lit_next = 1'b0;
                        end
                        else
                        begin
                            for (int i = 0; i < SelectorLeds; i++)
                            begin
                                if (sel_pos_next == PosW'(i))
                                begin
                                    frame_next[i] = pat_color_next;
                                end
                            end
                            blink_lit_next = 1'b1;
                        end
                        changed      = 1'b1;
                        elapsed_next = '0;
                        count_next   = count_reg + CountW'(1);
                    end
                end
                MODE_FANFARE:
                begin
                    if (count_reg == FanfareEnd)
                    begin
                        mode_next      = MODE_OFF;
                        elapsed_next   = ElapsedMax;
                        blink_lit_next = 1'b0;
                        count_next     = '0;
                    end
                    else if (elapsed_next >= FanfareMs)
                    begin
                        // centered bar, 2k leds wide, none when k is zero
                        for (int i = 0; i < SelectorLeds; i++)
                        begin
                            bar_on = (bar_k != 2'd0)
                                && ({1'b0, 3'(i)} + {2'b0, bar_k} >= 4'd3)
                                && (4'(i) <= {2'b0, bar_k} + 4'd2);
                            frame_next[i] = bar_on ? pat_color_next : '0;
                        end
                        changed      = 1'b1;
                        elapsed_next = '0;
                        count_next   = count_reg + CountW'(1);
                    end
                end
                default:
                begin
                    mode_next = MODE_OFF;
                end
            endcase

            // falling edge of the button latches the absolute index
            if (button_level)
            begin
                btn_held_next = 1'b0;
            end
            else if (!btn_held_reg)
            begin
                btn_held_next = 1'b1;
                click_next    = {1'b0, abs_index};
            end
        end
    end

    // absolute strip index from the new position
    assign off_clamped = (pixel_offset_reg > OffsetLimit) ? OffsetLimit : pixel_offset_reg;
    assign abs_index   = off_clamped + IndexW'(sel_pos_next);

    always_comb
    begin
        result_word = '0;
        for (int i = 0; i < SelectorLeds; i++)
        begin
            result_word[i*ColorW +: ColorW] = frame_next[i];
        end
        result_word[144]     = changed;
        result_word[149:145] = abs_index;
        result_word[155:150] = click_next;
        result_word[157:156] = mode_next;
    end

    // state registers advance once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_pos_reg   <= '0;
            last_a_reg    <= 1'b0;
            btn_held_reg  <= 1'b0;
            click_reg     <= ClickNone;
            mode_reg      <= MODE_OFF;
            pat_color_reg <= '0;
            blink_lit_reg <= 1'b0;
            count_reg     <= '0;
            elapsed_reg   <= ElapsedMax;
            frame_reg     <= '{default: '0};
        end
        else if (accept)
        begin
            sel_pos_reg   <= sel_pos_next;
            last_a_reg    <= last_a_next;
            btn_held_reg  <= btn_held_next;
            click_reg     <= click_next;
            mode_reg      <= mode_next;
            pat_color_reg <= pat_color_next;
            blink_lit_reg <= blink_lit_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            frame_reg     <= frame_next;
        end
    end

    // output register with skid: the skid register fills only when the
    // output word is stalled, and drains into the output register first
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result_word;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // checks
    `ESL_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg,
        "skid word held without an output word")
    `ESL_ASSERT(a_skid_drains, skid_valid_reg && m_axis_tready |=> out_valid_reg && !skid_valid_reg,
        "skid word not moved into the output register")
    `ESL_ASSERT(a_pos_range, sel_pos_reg <= MaxPos,
        "selector position beyond last led")
    `ESL_ASSERT(a_click_range, click_reg == ClickNone || click_reg < ClickW'(StripLength),
        "click mark outside the strip")
    `ESL_ASSERT(a_blink_lit_mode, $rose(blink_lit_reg) |-> mode_reg == MODE_BLINK,
        "blink lit outside blink mode")

endmodule
